[rtl/ftg_pkg.sv]
// Types and constants shared by the fall-time-to-ground pipeline.
// No dependencies.
package ftg_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int QBITS       = 15;
    localparam int NUM_W       = 66;
    localparam int LATENCY     = 3 + SQRT_STAGES + QBITS + 3;

    localparam logic signed [15:0] STEPS_MAX = 16'sd32767;

    typedef struct packed {
        logic signed [31:0] height;
        logic signed [31:0] velocity;
        logic signed [31:0] terminal_speed;
        logic signed [31:0] accel;
    } ftg_in_t;

    typedef struct packed {
        logic signed [15:0] steps;
        logic               rejected;
    } ftg_out_t;

    // per-item data carried alongside the square root
    typedef struct packed {
        logic               rej;
        logic               use_a;
        logic               tvz;
        logic [NUM_W-1:0]   num_a;
        logic [NUM_W-1:0]   den_a;
        logic signed [31:0] velocity;
        logic [31:0]        g;
    } ftg_side_t;

endpackage

[rtl/ftg_prep.sv]
// Input register, product stage and discriminant stage.
// Depends on ftg_pkg.
module ftg_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  ftg_pkg::ftg_in_t operand,
    output logic             out_valid,
    output logic [63:0]      disc,
    output ftg_pkg::ftg_side_t side
);
    import ftg_pkg::*;

    ftg_in_t            in_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [63:0]        vv_reg, tt_reg, uu_reg, gw_reg;
    logic [62:0]        gh_reg;
    logic               rej_reg, tvz_reg;
    logic signed [31:0] vel_reg;
    logic [31:0]        g_reg;
    logic [63:0]        disc_reg;
    ftg_side_t          side_reg;

    logic               rej_next, tvz_next;
    logic [31:0]        g_next, w_next, ud_next;
    logic signed [32:0] d_next;
    logic [63:0]        two_gh;
    logic [64:0]        rhs;
    ftg_side_t          side_next;

    always_comb
    begin
        rej_next = in_reg.height[31]
                 | (!in_reg.terminal_speed[31] && in_reg.terminal_speed != 32'sd0)
                 | !in_reg.accel[31];
        tvz_next = (in_reg.terminal_speed == 32'sd0);
        g_next   = 32'(33'd0 - 33'(unsigned'(in_reg.accel)));
        w_next   = 32'(33'd0 - 33'(unsigned'(in_reg.terminal_speed)));
        d_next   = 33'(in_reg.terminal_speed) - 33'(in_reg.velocity);
        ud_next  = d_next[32] ? 32'(-d_next) : d_next[31:0];
    end

    always_comb
    begin
        two_gh            = {gh_reg, 1'b0};
        rhs               = 65'(vv_reg) + 65'(two_gh);
        side_next.rej     = rej_reg;
        side_next.use_a   = (65'(tt_reg) < rhs);
        side_next.tvz     = tvz_reg;
        side_next.num_a   = {1'b0, uu_reg, 1'b0} + {1'b0, two_gh, 1'b0}
                          + {1'b0, gw_reg, 1'b0};
        side_next.den_a   = {gw_reg, 2'b00};
        side_next.velocity = vel_reg;
        side_next.g       = g_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= operand;
        vv_reg   <= unsigned'(64'(in_reg.velocity * in_reg.velocity));
        tt_reg   <= unsigned'(64'(in_reg.terminal_speed * in_reg.terminal_speed));
        gh_reg   <= 63'(g_next) * 63'(in_reg.height[30:0]);
        uu_reg   <= 64'(ud_next) * 64'(ud_next);
        gw_reg   <= 64'(g_next) * 64'(w_next);
        rej_reg  <= rej_next;
        tvz_reg  <= tvz_next;
        vel_reg  <= in_reg.velocity;
        g_reg    <= g_next;
        disc_reg <= rhs[63:0];
        side_reg <= side_next;
    end

    assign out_valid = v3_reg;
    assign disc      = disc_reg;
    assign side      = side_reg;

endmodule

[rtl/ftg_sqrt.sv]
// Pipelined integer square root, one result bit per stage; carries side data.
// Depends on ftg_pkg.
module ftg_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [63:0]        disc,
    input  ftg_pkg::ftg_side_t in_side,
    output logic               out_valid,
    output logic [31:0]        root,
    output logic [63:0]        remainder,
    output ftg_pkg::ftg_side_t out_side
);
    import ftg_pkg::*;

    logic        val_reg  [0:SQRT_STAGES];
    logic [63:0] n_reg    [0:SQRT_STAGES];
    logic [63:0] res_reg  [0:SQRT_STAGES];
    ftg_side_t   side_reg [0:SQRT_STAGES];

    always_comb
    begin
        val_reg[0]  = in_valid;
        n_reg[0]    = disc;
        res_reg[0]  = 64'd0;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        logic [63:0] n_next, res_next;

        always_comb
        begin
            trial = res_reg[i] + BIT;
            if (n_reg[i] >= trial)
            begin
                n_next   = n_reg[i] - trial;
                res_next = (res_reg[i] >> 1) + BIT;
            end
            else
            begin
                n_next   = n_reg[i];
                res_next = res_reg[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[i+1] <= 1'b0;
            else
                val_reg[i+1] <= val_reg[i];
        end

        always_ff @(posedge clk)
        begin
            n_reg[i+1]    <= n_next;
            res_reg[i+1]  <= res_next;
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = val_reg[SQRT_STAGES];
    assign root      = res_reg[SQRT_STAGES][31:0];
    assign remainder = n_reg[SQRT_STAGES];
    assign out_side  = side_reg[SQRT_STAGES];

endmodule

[rtl/ftg_div.sv]
// Operand select, saturating restoring divider (one quotient bit per stage)
// and result register. Depends on ftg_pkg.
module ftg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        root,
    input  logic [63:0]        remainder,
    input  ftg_pkg::ftg_side_t side,
    output logic               done,
    output ftg_pkg::ftg_out_t  result
);
    import ftg_pkg::*;

    localparam int CW = NUM_W + QBITS;

    // select stage
    logic             sv_reg, sr_reg, sf_reg;
    logic [NUM_W-1:0] snum_reg, sden_reg;

    logic [33:0]      f2;
    logic [35:0]      x;
    logic [NUM_W-1:0] num_next, den_next;

    always_comb
    begin
        f2 = {1'b0, root, 1'b0} + 34'(remainder > 64'(root));
        x  = 36'(f2) + {{3{side.velocity[31]}}, side.velocity, 1'b0} + 36'(side.g);
        if (side.use_a)
        begin
            num_next = side.num_a;
            den_next = side.den_a;
        end
        else
        begin
            num_next = (!x[35] && x != 36'd0) ? NUM_W'(x) : '0;
            den_next = NUM_W'({side.g, 1'b0});
        end
    end

    // division stages: index 0 is the saturation check
    logic             val_reg [0:QBITS];
    logic             rej_reg [0:QBITS];
    logic             sat_reg [0:QBITS];
    logic [NUM_W-1:0] rem_reg [0:QBITS];
    logic [NUM_W-1:0] den_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg     <= 1'b0;
            val_reg[0] <= 1'b0;
        end
        else
        begin
            sv_reg     <= in_valid;
            val_reg[0] <= sv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg     <= side.rej;
        sf_reg     <= side.use_a & side.tvz;
        snum_reg   <= num_next;
        sden_reg   <= den_next;
        rej_reg[0] <= sr_reg;
        sat_reg[0] <= sf_reg | ({QBITS'(0), snum_reg} >= {sden_reg, QBITS'(0)});
        rem_reg[0] <= snum_reg;
        den_reg[0] <= sden_reg;
        q_reg[0]   <= '0;
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_stage
        localparam int SH = QBITS - 1 - j;
        logic [CW-1:0]    trial;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [QBITS-1:0] q_next;

        always_comb
        begin
            trial    = CW'(den_reg[j]) << SH;
            take     = CW'(rem_reg[j]) >= trial;
            rem_next = take ? NUM_W'(CW'(rem_reg[j]) - trial) : rem_reg[j];
            q_next   = q_reg[j];
            q_next[SH] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[j+1] <= 1'b0;
            else
                val_reg[j+1] <= val_reg[j];
        end

        always_ff @(posedge clk)
        begin
            rej_reg[j+1] <= rej_reg[j];
            sat_reg[j+1] <= sat_reg[j];
            rem_reg[j+1] <= rem_next;
            den_reg[j+1] <= den_reg[j];
            q_reg[j+1]   <= q_next;
        end
    end

    logic     done_reg;
    ftg_out_t res_reg;
    ftg_out_t res_next;

    always_comb
    begin
        res_next.rejected = rej_reg[QBITS];
        if (rej_reg[QBITS])
            res_next.steps = 16'sd0;
        else if (sat_reg[QBITS])
            res_next.steps = STEPS_MAX;
        else
            res_next.steps = signed'({1'b0, q_reg[QBITS]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= val_reg[QBITS];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/fall_time_to_ground_top.sv]
// Fall time to ground: top level of the pipeline.
// Stages in order: prep, square root, operand select, saturation check, divider, result.
// Throughput: one transaction per cycle; the square-root and divider stages
// each retire one bit per stage. busy stays low.
// Reset clears the valid bits only; transactions in flight are dropped.
// Depends on ftg_pkg, ftg_prep, ftg_sqrt, ftg_div.
module fall_time_to_ground_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ftg_pkg::ftg_in_t  operand,
    output logic              done,
    output ftg_pkg::ftg_out_t result
);
    import ftg_pkg::*;

    logic        p_valid, s_valid;
    logic [63:0] p_disc, s_rem;
    logic [31:0] s_root;
    ftg_side_t   p_side, s_side;

    assign busy = 1'b0;

    ftg_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .operand   (operand),
        .out_valid (p_valid),
        .disc      (p_disc),
        .side      (p_side)
    );

    ftg_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .disc      (p_disc),
        .in_side   (p_side),
        .out_valid (s_valid),
        .root      (s_root),
        .remainder (s_rem),
        .out_side  (s_side)
    );

    ftg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .root      (s_root),
        .remainder (s_rem),
        .side      (s_side),
        .done      (done),
        .result    (result)
    );

endmodule

[rtl/ftg_checker.sv]
// Port-level checks for fall_time_to_ground_top, bound to the top level.
// Depends on ftg_pkg.
module ftg_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ftg_pkg::ftg_in_t  operand,
    input logic              done,
    input ftg_pkg::ftg_out_t result
);
    import ftg_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("transaction did not complete on time");

    a_guard: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operand.height[31] || !operand.accel[31])
        |-> ##LATENCY result.rejected)
        else $error("invalid transaction not rejected");

    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.rejected |-> result.steps == 16'sd0)
        else $error("rejected result with nonzero steps");

    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result.steps[15])
        else $error("negative step count");

endmodule

bind fall_time_to_ground_top ftg_port_checker u_ftg_port_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
);

[tb/sv/ftg_checker.sv]
// Checker for the fall-time-to-ground block: predicts each result from the
// accepted operands and compares it with the done strobe. Depends on ftg_pkg.
module ftg_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ftg_pkg::ftg_in_t  operand,
    input  logic              done,
    input  ftg_pkg::ftg_out_t result,
    output int                fail_count,
    output int                pending
);
    import ftg_pkg::*;

    localparam longint unsigned CAP = 64'd32767;

    ftg_out_t landing_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // round (p + q) / den to nearest, saturating
    function automatic longint unsigned rounded_quotient(longint unsigned p,
        longint unsigned q, longint unsigned den);
        longint unsigned qp, qq, r, cnt;
        qp = p / den;
        qq = q / den;
        if (qp > CAP || qq > CAP)
            return CAP;
        cnt = qp + qq;
        r   = (p % den) + (q % den);
        if (r >= den)
        begin
            cnt++;
            r -= den;
        end
        if (r >= den - r)
            cnt++;
        return (cnt > CAP) ? CAP : cnt;
    endfunction

    function automatic ftg_out_t predict_landing(ftg_in_t op);
        longint h, v, tv, a, d, x;
        longint unsigned g, two_gh, n, disc, r, f2, cnt, ud;
        ftg_out_t o;
        h  = op.height;
        v  = op.velocity;
        tv = op.terminal_speed;
        a  = op.accel;
        o  = '0;
        if (h < 0 || tv > 0 || a >= 0)
        begin
            o.rejected = 1'b1;
            return o;
        end
        g      = -a;
        two_gh = 2 * g * longint'(h);
        if (tv * tv - longint'(two_gh) < v * v)
        begin
            if (tv == 0)
                n = CAP;
            else
            begin
                d  = tv - v;
                ud = (d < 0) ? -d : d;
                n  = rounded_quotient(ud * ud, two_gh, 2 * g * longint'(-tv));
            end
        end
        else
        begin
            disc = longint'(v * v) + two_gh;
            r    = int_sqrt(disc);
            f2   = 2 * r + ((r * r + r < disc) ? 1 : 0);
            x    = longint'(f2) + 2 * v + longint'(g);
            cnt  = (x > 0) ? longint'(x) / (2 * g) : 0;
            n    = (cnt > CAP) ? CAP : cnt;
        end
        o.steps = n[15:0];
        return o;
    endfunction

    assign pending = landing_q.size();

    initial
        fail_count = 0;

    always @(posedge clk)
    begin
        ftg_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (landing_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %p", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = landing_q.pop_front();
                    if (want.steps !== result.steps || want.rejected !== result.rejected)
                    begin
                        $display("%0t: expected %p, actual %p", $time, want, result);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                landing_q.push_back(predict_landing(operand));
        end
    end
endmodule

[tb/sv/testbench.sv]
// Stimulus and verdict for fall_time_to_ground_top; checking is in ftg_checker.
// Depends on ftg_pkg, fall_time_to_ground_top, ftg_checker.
module testbench;
    import ftg_pkg::*;

    localparam int N_RANDOM = 930;
    localparam int WATCHDOG = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ftg_in_t  operand;
    logic     done;
    ftg_out_t result;
    int       fail_count;
    int       pending;
    int       quiet_cycles;

    fall_time_to_ground_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operand(operand), .done(done), .result(result)
    );

    ftg_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operand(operand),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial
        clk = 1'b0;
    always #2 clk = ~clk;

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // mostly valid operands with scales that land in range and cross terminal speed
    function automatic ftg_in_t random_operand();
        ftg_in_t op;
        op.height         = $urandom_range(0, 32'h0100_0000) >> $urandom_range(0, 24);
        op.velocity       = $signed($urandom) >>> $urandom_range(8, 31);
        op.terminal_speed = -($urandom_range(0, 32'h0080_0000) >> $urandom_range(0, 23));
        op.accel          = -(($urandom_range(1, 32'h0001_0000) >> $urandom_range(0, 16)) + 1);
        case ($urandom_range(0, 9))
            0: op.height = rand_word();
            1: op.velocity = rand_word();
            2: op.terminal_speed = rand_word();
            3: op.accel = rand_word();
            4: op = {rand_word(), rand_word(), rand_word(), rand_word()};
            default: ;
        endcase
        return op;
    endfunction

    task automatic send(ftg_in_t op, bit may_idle);
        if (may_idle)
            while ($urandom_range(0, 99) < 13)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start   <= 1'b1;
        operand <= op;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        ftg_in_t corner[$];
        ftg_in_t op;
        int      settle;
        rst_n        = 1'b0;
        start        = 1'b0;
        operand      = '0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        corner.push_back('{32'sh0001_0000, 0, -32'sh0010_0000, -32'sh0001_0000});
        corner.push_back('{-1, 0, -32'sh0001_0000, -32'sh0001_0000});
        corner.push_back('{32'sh0001_0000, 0, 1, -32'sh0001_0000});
        corner.push_back('{32'sh0001_0000, 0, -32'sh0001_0000, 0});
        corner.push_back('{32'sh0001_0000, 0, -32'sh0001_0000, 1});
        corner.push_back('{32'sh0100_0000, 0, 0, -32'sh0000_1000});
        corner.push_back('{0, 0, 0, -1});
        corner.push_back('{0, 32'sh7fff_ffff, -1, -1});
        corner.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000});
        corner.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 0, -1});
        corner.push_back('{32'sh7fff_ffff, 0, -1, -1});
        corner.push_back('{32'sh7fff_ffff, 0, 32'sh8000_0000, -1});
        // height left at terminal speed exactly zero: v=0, tv=-2, g=1, h=2
        corner.push_back('{32'sd2, 0, -32'sd2, -32'sd1});
        corner.push_back('{32'sh0008_0000, -32'sh0004_0000, -32'sh0002_0000,
                           -32'sh0000_8000});
        corner.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh7fff_ffff});
        corner.push_back('{32'sh0000_0001, 32'sh8000_0000, -32'sh0000_0001,
                           -32'sh0000_0001});
        corner.push_back('{32'sh0100_0000, 32'sh0001_0000, -32'sh0000_0100,
                           -32'sh0000_0010});
        foreach (corner[i])
            send(corner[i], 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = random_operand();
            send(op, !(i >= 300 && i < 450));
        end
        start <= 1'b0;

        settle = 0;
        while (pending != 0 && settle < 10 * LATENCY + 100)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[fall_time_to_ground_top.f]
rtl/ftg_pkg.sv
rtl/ftg_prep.sv
rtl/ftg_sqrt.sv
rtl/ftg_div.sv
rtl/fall_time_to_ground_top.sv
rtl/ftg_checker.sv
tb/sv/ftg_checker.sv
tb/sv/testbench.sv
